// ----- hw/rtl/hvps_pkg.sv -----
// Shared types, register indexes, reset values and state codes for the HV precharge sequencer.
package hvps_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FUSE_LIMIT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECHARGE_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA      = 3'd4;

    // Register reset values.
    localparam logic [14:0] FUSE_LIMIT_RST        = 15'd2750;
    localparam logic [14:0] CURRENT_LIMIT_RST     = 15'd2500;
    localparam logic [15:0] PRECHARGE_MARGIN_RST  = 16'd2000;
    localparam logic [15:0] PRECHARGE_TIMEOUT_RST = 16'd500;
    localparam logic [16:0] FILTER_ALPHA_RST      = 17'd25288;

    // Filtered trip level cap (25 A) and unity filter gain in Q16.
    localparam logic [14:0] FILTER_CAP = 15'd2500;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;

    // Externally visible sequencer state codes.
    localparam logic [2:0] SEQ_CODE_OFF      = 3'd0;
    localparam logic [2:0] SEQ_CODE_PC_START = 3'd1;
    localparam logic [2:0] SEQ_CODE_PC       = 3'd2;
    localparam logic [2:0] SEQ_CODE_ON       = 3'd3;
    localparam logic [2:0] SEQ_CODE_SHUT     = 3'd4;

    typedef enum logic [4:0] {
        SEQ_OFF      = 5'b00001,
        SEQ_PC_START = 5'b00010,
        SEQ_PC       = 5'b00100,
        SEQ_ON       = 5'b01000,
        SEQ_SHUT     = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               enable;
        logic [15:0]        battery_a_mv;
        logic [15:0]        battery_b_mv;
        logic [15:0]        output_mv;
        logic               current_valid;
        logic signed [15:0] current_sample;
    } in_item_t;

    typedef struct packed {
        logic               precharge_on;
        logic               main_switch_on;
        logic [2:0]         seq_state;
        logic               fuse_trip;
        logic               overcurrent_trip;
        logic               precharge_fail;
        logic signed [15:0] filtered_current;
    } out_item_t;

    // Raw over-current conditions from the filter datapath.
    typedef struct packed {
        logic over_fuse;
        logic over_level;
    } trip_req_t;

    // Event flags reported by the sequencer for one item.
    typedef struct packed {
        logic fuse_trip;
        logic overcurrent_trip;
        logic precharge_fail;
    } seq_flags_t;

endpackage

// ----- hw/rtl/hvps_filter.sv -----
// Current low-pass filter update and over-current comparisons.
module hvps_filter (
    input  logic signed [31:0]  acc,
    input  logic                sample_valid,
    input  logic signed [15:0]  sample,
    input  logic [14:0]         fuse_limit,
    input  logic [14:0]         current_limit,
    input  logic [16:0]         alpha,
    output logic signed [31:0]  acc_next,
    output logic signed [15:0]  filtered_current,
    output hvps_pkg::trip_req_t trip
);

    logic [16:0]        alpha_eff;
    logic [14:0]        level;
    logic signed [32:0] target;
    logic signed [32:0] acc_ext;
    logic signed [32:0] diff;
    logic signed [17:0] alpha_s;
    logic signed [50:0] prod;
    logic signed [50:0] rounded;
    logic signed [34:0] step;
    logic signed [31:0] acc_upd;
    logic [15:0]        int_part;

    always_comb begin
        alpha_eff = (alpha > hvps_pkg::ALPHA_ONE) ? hvps_pkg::ALPHA_ONE : alpha;
        level     = (current_limit < hvps_pkg::FILTER_CAP) ? current_limit : hvps_pkg::FILTER_CAP;
        target    = $signed({sample[15], sample, 16'd0});
        acc_ext   = $signed({acc[31], acc});
        diff      = target - acc_ext;
        alpha_s   = $signed({1'b0, alpha_eff});
        prod      = diff * alpha_s;
        // Round to nearest, ties up, then floor divide by 65536.
        rounded   = prod + 51'sd32768;
        step      = $signed(rounded[50:16]);
        acc_upd   = acc + step[31:0];
        acc_next  = sample_valid ? acc_upd : acc;

        trip.over_fuse  = sample_valid && (sample > $signed({1'b0, fuse_limit}));
        trip.over_level = sample_valid && (acc_upd > $signed({1'b0, level, 16'd0}));

        // Integer part truncated toward zero.
        int_part = acc_next[31:16];
        if (acc_next[31] && (acc_next[15:0] != 16'd0)) begin
            int_part = acc_next[31:16] + 16'd1;
        end
        filtered_current = $signed(int_part);
    end

endmodule

// ----- hw/rtl/hvps_seq.sv -----
// Next-state logic of the five-state precharge sequencer, including trip handling.
module hvps_seq (
    input  hvps_pkg::seq_state_t state,
    input  logic                 precharge,
    input  logic                 main_switch,
    input  logic [31:0]          start_ms,
    input  logic [31:0]          now_ms,
    input  logic                 enable,
    input  logic [15:0]          battery_a_mv,
    input  logic [15:0]          battery_b_mv,
    input  logic [15:0]          output_mv,
    input  hvps_pkg::trip_req_t  trip,
    input  logic [15:0]          margin,
    input  logic [15:0]          timeout,
    output hvps_pkg::seq_state_t state_next,
    output logic                 precharge_next,
    output logic                 main_switch_next,
    output logic [31:0]          start_ms_next,
    output logic [2:0]           state_code,
    output hvps_pkg::seq_flags_t flags
);

    hvps_pkg::seq_state_t mid_state;
    logic [15:0]          vmax;
    logic signed [17:0]   headroom;
    logic [31:0]          elapsed;

    always_comb begin
        flags.fuse_trip        = trip.over_fuse && (state != hvps_pkg::SEQ_SHUT);
        flags.overcurrent_trip = trip.over_level && (state != hvps_pkg::SEQ_SHUT)
                                 && !flags.fuse_trip;
        flags.precharge_fail   = 1'b0;

        mid_state = (flags.fuse_trip || flags.overcurrent_trip) ? hvps_pkg::SEQ_SHUT : state;

        vmax     = (battery_a_mv > battery_b_mv) ? battery_a_mv : battery_b_mv;
        headroom = $signed({2'b00, vmax}) - $signed({2'b00, output_mv});
        elapsed  = now_ms - start_ms;

        state_next       = mid_state;
        precharge_next   = precharge;
        main_switch_next = main_switch;
        start_ms_next    = start_ms;

        unique case (mid_state)
            hvps_pkg::SEQ_OFF: begin
                if (enable) begin
                    state_next = hvps_pkg::SEQ_PC_START;
                end
            end
            hvps_pkg::SEQ_PC_START: begin
                precharge_next = 1'b1;
                start_ms_next  = now_ms;
                state_next     = hvps_pkg::SEQ_PC;
            end
            hvps_pkg::SEQ_PC: begin
                if (headroom < $signed({2'b00, margin})) begin
                    precharge_next   = 1'b0;
                    main_switch_next = 1'b1;
                    state_next       = hvps_pkg::SEQ_ON;
                end else if (elapsed > {16'd0, timeout}) begin
                    flags.precharge_fail = 1'b1;
                    state_next           = hvps_pkg::SEQ_SHUT;
                end
            end
            hvps_pkg::SEQ_ON: begin
                if (!enable) begin
                    state_next = hvps_pkg::SEQ_SHUT;
                end
            end
            default: begin
                precharge_next   = 1'b0;
                main_switch_next = 1'b0;
                state_next       = hvps_pkg::SEQ_OFF;
            end
        endcase

        unique case (state_next)
            hvps_pkg::SEQ_OFF:      state_code = hvps_pkg::SEQ_CODE_OFF;
            hvps_pkg::SEQ_PC_START: state_code = hvps_pkg::SEQ_CODE_PC_START;
            hvps_pkg::SEQ_PC:       state_code = hvps_pkg::SEQ_CODE_PC;
            hvps_pkg::SEQ_ON:       state_code = hvps_pkg::SEQ_CODE_ON;
            default:                state_code = hvps_pkg::SEQ_CODE_SHUT;
        endcase
    end

endmodule

// ----- hw/rtl/hv_precharge_overcurrent_sequencer_core.sv -----
// Top level of the HV precharge sequencer with instant and filtered over-current trips.
//
// Usage:
// Each item on the s_ channel (s_valid, s_ready, s_data) is one control tick: a
// millisecond timestamp, the enable request, two battery voltages, the output voltage
// and an optional current sample. Each accepted item yields exactly one result item
// on the m_ channel (m_valid, m_ready, m_data) with the switch drives, the sequencer
// state after the tick, the trip and failure events of the tick and the filtered current.
// An accepted item sits in the input register; once the result register is free or is
// being emptied, the filter update, the trip checks and the sequencer step run in one
// pass and load the result register. The block takes one item per cycle while m_ready
// stays high: the input register refills in the same cycle that it hands its item on.
// The filter feedback loop (subtract, one 33 x 18 multiply, add) sets the clock period.
// When the receiver stalls, the result register holds, the input register keeps one
// more item and s_ready then drops until m_ready returns.
// Configuration is written via cfg_wr_en, cfg_index and cfg_wdata, by the user only while
// the block is idle, which it does not enforce; unknown indexes are ignored. Synchronous
// active-low reset aresetn restores the register defaults, puts the sequencer in Off with
// both switches open, clears the filter and precharge timestamp, empties both registers.
module hv_precharge_overcurrent_sequencer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  hvps_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hvps_pkg::out_item_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [hvps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hvps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Configuration registers.
    logic [14:0] fuse_limit_reg;
    logic [14:0] current_limit_reg;
    logic [15:0] precharge_margin_reg;
    logic [15:0] precharge_timeout_reg;
    logic [16:0] filter_alpha_reg;

    // Pipeline registers.
    hvps_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    hvps_pkg::out_item_t out_reg;
    logic                out_valid_reg;

    // Sequencer and filter state.
    hvps_pkg::seq_state_t seq_reg;
    hvps_pkg::seq_state_t seq_next;
    logic                 precharge_reg;
    logic                 precharge_next;
    logic                 switch_reg;
    logic                 switch_next;
    logic [31:0]          precharge_start_reg;
    logic [31:0]          precharge_start_next;
    logic signed [31:0]   filter_acc_reg;
    logic signed [31:0]   filter_acc_next;

    hvps_pkg::trip_req_t  trip;
    hvps_pkg::seq_flags_t flags;
    logic [2:0]           state_code;
    logic signed [15:0]   filtered_current;
    logic                 advance;

    // The item in the input register moves on whenever the result register is free
    // or is being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    hvps_filter u_filter (
        .acc              (filter_acc_reg),
        .sample_valid     (in_reg.current_valid),
        .sample           (in_reg.current_sample),
        .fuse_limit       (fuse_limit_reg),
        .current_limit    (current_limit_reg),
        .alpha            (filter_alpha_reg),
        .acc_next         (filter_acc_next),
        .filtered_current (filtered_current),
        .trip             (trip)
    );

    hvps_seq u_seq (
        .state            (seq_reg),
        .precharge        (precharge_reg),
        .main_switch      (switch_reg),
        .start_ms         (precharge_start_reg),
        .now_ms           (in_reg.now_ms),
        .enable           (in_reg.enable),
        .battery_a_mv     (in_reg.battery_a_mv),
        .battery_b_mv     (in_reg.battery_b_mv),
        .output_mv        (in_reg.output_mv),
        .trip             (trip),
        .margin           (precharge_margin_reg),
        .timeout          (precharge_timeout_reg),
        .state_next       (seq_next),
        .precharge_next   (precharge_next),
        .main_switch_next (switch_next),
        .start_ms_next    (precharge_start_next),
        .state_code       (state_code),
        .flags            (flags)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fuse_limit_reg        <= hvps_pkg::FUSE_LIMIT_RST;
            current_limit_reg     <= hvps_pkg::CURRENT_LIMIT_RST;
            precharge_margin_reg  <= hvps_pkg::PRECHARGE_MARGIN_RST;
            precharge_timeout_reg <= hvps_pkg::PRECHARGE_TIMEOUT_RST;
            filter_alpha_reg      <= hvps_pkg::FILTER_ALPHA_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hvps_pkg::CFG_FUSE_LIMIT:        fuse_limit_reg        <= cfg_wdata[14:0];
                hvps_pkg::CFG_CURRENT_LIMIT:     current_limit_reg     <= cfg_wdata[14:0];
                hvps_pkg::CFG_PRECHARGE_MARGIN:  precharge_margin_reg  <= cfg_wdata[15:0];
                hvps_pkg::CFG_PRECHARGE_TIMEOUT: precharge_timeout_reg <= cfg_wdata[15:0];
                hvps_pkg::CFG_FILTER_ALPHA:      filter_alpha_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register: loads whenever the handshake completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Block state steps once per processed item, together with the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg             <= hvps_pkg::SEQ_OFF;
            precharge_reg       <= 1'b0;
            switch_reg          <= 1'b0;
            precharge_start_reg <= 32'd0;
            filter_acc_reg      <= 32'sd0;
            out_valid_reg       <= 1'b0;
        end else begin
            if (advance) begin
                seq_reg             <= seq_next;
                precharge_reg       <= precharge_next;
                switch_reg          <= switch_next;
                precharge_start_reg <= precharge_start_next;
                filter_acc_reg      <= filter_acc_next;
                out_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg.precharge_on     <= precharge_next;
            out_reg.main_switch_on   <= switch_next;
            out_reg.seq_state        <= state_code;
            out_reg.fuse_trip        <= flags.fuse_trip;
            out_reg.overcurrent_trip <= flags.overcurrent_trip;
            out_reg.precharge_fail   <= flags.precharge_fail;
            out_reg.filtered_current <= filtered_current;
        end
    end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the HV precharge sequencer with over-current trips.
`timescale 1ns / 100ps

module tb;
    import hvps_pkg::*;

    // Random items per configuration phase; there are seven phases after the
    // directed part, which comes to about 1450 items in all.
    localparam int PHASE_ITEMS = 205;
    localparam int PHASES      = 7;
    localparam int DRILL_N     = 25;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    hv_precharge_overcurrent_sequencer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Generous fixed limit; a correct run needs a few percent of it.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mirror of the register file as the block should hold it.
    logic [14:0] fuse_lim_q;
    logic [14:0] cur_lim_q;
    logic [15:0] margin_q;
    logic [15:0] timeout_q;
    logic [16:0] alpha_q;

    // Mirror of the sequencer and filter state.
    logic [2:0]  seq_q;
    logic [31:0] pc_stamp_q;
    longint      filt_acc_q;
    logic        pc_drive_q;
    logic        main_drive_q;

    // Results owed by the block, oldest first.
    out_item_t   awaited_ticks[$];
    int          fault_count = 0;

    // When set, neither side inserts idle cycles.
    bit          calm = 1'b0;
    int          stall_left = 0;

    // Stimulus shaping state for the random part.
    logic [31:0] ms_clock;
    bit          want_on;
    int          surge_left;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } drill_row_t;

    drill_row_t drill[DRILL_N];

    function automatic in_item_t mk_tick(logic [31:0] now, logic en, logic [15:0] va,
                                         logic [15:0] vb, logic [15:0] vo, logic cv,
                                         int cur);
        in_item_t t;
        t.now_ms         = now;
        t.enable         = en;
        t.battery_a_mv   = va;
        t.battery_b_mv   = vb;
        t.output_mv      = vo;
        t.current_valid  = cv;
        t.current_sample = 16'(cur);
        return t;
    endfunction

    function automatic out_item_t mk_out(logic pc, logic sw, logic [2:0] st);
        out_item_t r;
        r                  = '0;
        r.precharge_on     = pc;
        r.main_switch_on   = sw;
        r.seq_state        = st;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_FUSE_LIMIT:        fuse_lim_q = val[14:0];
            CFG_CURRENT_LIMIT:     cur_lim_q  = val[14:0];
            CFG_PRECHARGE_MARGIN:  margin_q   = val[15:0];
            CFG_PRECHARGE_TIMEOUT: timeout_q  = val[15:0];
            CFG_FILTER_ALPHA:      alpha_q    = val;
            default: ;
        endcase
    endfunction

    // One control tick: instant trip, filter update, filtered trip, then one
    // sequencer step. Returns the result the block must produce for it.
    function automatic out_item_t step_sequencer(in_item_t t);
        longint      cur;
        longint      gain;
        longint      level;
        longint      diff;
        int          va;
        int          vb;
        int          vo;
        int          vmax;
        logic [31:0] elapsed;
        out_item_t   r;

        r   = '0;
        cur = longint'($signed(t.current_sample));
        if (t.current_valid) begin
            // Gains above unity saturate so the filter cannot overshoot.
            gain  = (alpha_q > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_q);
            level = (cur_lim_q < FILTER_CAP) ? longint'(cur_lim_q) : longint'(FILTER_CAP);
            if (cur > longint'(fuse_lim_q) && seq_q != SEQ_CODE_SHUT) begin
                seq_q       = SEQ_CODE_SHUT;
                r.fuse_trip = 1'b1;
            end
            // Round to nearest, ties upward: the arithmetic shift floors.
            diff       = cur * 65536 - filt_acc_q;
            filt_acc_q = filt_acc_q + ((diff * gain + 32768) >>> 16);
            if (filt_acc_q > level * 65536 && seq_q != SEQ_CODE_SHUT) begin
                seq_q              = SEQ_CODE_SHUT;
                r.overcurrent_trip = 1'b1;
            end
        end

        case (seq_q)
            SEQ_CODE_OFF: begin
                if (t.enable)
                    seq_q = SEQ_CODE_PC_START;
            end
            SEQ_CODE_PC_START: begin
                pc_drive_q = 1'b1;
                pc_stamp_q = t.now_ms;
                seq_q      = SEQ_CODE_PC;
            end
            SEQ_CODE_PC: begin
                va      = t.battery_a_mv;
                vb      = t.battery_b_mv;
                vo      = t.output_mv;
                vmax    = (va > vb) ? va : vb;
                elapsed = t.now_ms - pc_stamp_q;
                if (vmax - vo < int'({16'b0, margin_q})) begin
                    pc_drive_q   = 1'b0;
                    main_drive_q = 1'b1;
                    seq_q        = SEQ_CODE_ON;
                end else if (elapsed > {16'b0, timeout_q}) begin
                    r.precharge_fail = 1'b1;
                    seq_q            = SEQ_CODE_SHUT;
                end
            end
            SEQ_CODE_ON: begin
                if (!t.enable)
                    seq_q = SEQ_CODE_SHUT;
            end
            default: begin
                pc_drive_q   = 1'b0;
                main_drive_q = 1'b0;
                seq_q        = SEQ_CODE_OFF;
            end
        endcase

        r.precharge_on     = pc_drive_q;
        r.main_switch_on   = main_drive_q;
        r.seq_state        = seq_q;
        r.filtered_current = 16'(filt_acc_q / 65536);
        return r;
    endfunction

    // Random tick that mostly follows a plausible power-up: a slowly advancing
    // clock, a steady enable request, an output rail near the batteries and
    // current samples that are usually modest but sometimes surge or spike.
    function automatic in_item_t random_tick();
        in_item_t t;
        int       pick;
        int       va;
        int       vb;
        int       vmax;
        int       cur;

        pick = $urandom_range(0, 99);
        if (pick < 90)
            ms_clock = ms_clock + $urandom_range(0, 60);
        else if (pick < 97)
            ms_clock = ms_clock + $urandom_range(400, 700);
        else
            ms_clock = $urandom;

        if ($urandom_range(0, 24) == 0)
            want_on = !want_on;

        t.now_ms = ms_clock;
        t.enable = ($urandom_range(0, 19) == 0) ? !want_on : want_on;

        if ($urandom_range(0, 9) < 2) begin
            t.battery_a_mv = 16'($urandom);
            t.battery_b_mv = 16'($urandom);
            t.output_mv    = 16'($urandom);
        end else begin
            va             = $urandom_range(30000, 60000);
            vb             = $urandom_range(30000, 60000);
            vmax           = (va > vb) ? va : vb;
            t.battery_a_mv = 16'(va);
            t.battery_b_mv = 16'(vb);
            // Sometimes the rail sits above both batteries.
            if ($urandom_range(0, 3) == 0)
                t.output_mv = 16'($urandom);
            else
                t.output_mv = 16'(vmax - $urandom_range(0, 4000));
        end

        if (surge_left == 0 && $urandom_range(0, 33) == 0)
            surge_left = $urandom_range(5, 15);

        if (surge_left != 0) begin
            surge_left      = surge_left - 1;
            t.current_valid = 1'b1;
            cur             = $urandom_range(2450, 2760);
        end else begin
            t.current_valid = ($urandom_range(0, 9) < 7);
            pick            = $urandom_range(0, 9);
            if (pick < 7)
                cur = $urandom_range(0, 1200) - 600;
            else if (pick < 8)
                cur = int'(fuse_lim_q) + $urandom_range(0, 40) - 20;
            else
                cur = $urandom;
        end
        t.current_sample = 16'(cur);
        return t;
    endfunction

    // The monitor samples the block's outputs at the clock edge, where the
    // block itself samples m_ready, so an accepted result is seen exactly once.
    task automatic report(string why, out_item_t want, out_item_t got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t %s: exp pc=%0b sw=%0b st=%0d fuse=%0b oc=%0b fail=%0b filt=%0d",
                     $realtime, why, want.precharge_on, want.main_switch_on,
                     want.seq_state, want.fuse_trip, want.overcurrent_trip,
                     want.precharge_fail, $signed(want.filtered_current));
            $display("%0t %s: got pc=%0b sw=%0b st=%0d fuse=%0b oc=%0b fail=%0b filt=%0d",
                     $realtime, why, got.precharge_on, got.main_switch_on,
                     got.seq_state, got.fuse_trip, got.overcurrent_trip,
                     got.precharge_fail, $signed(got.filtered_current));
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_ticks.size() == 0) begin
                report("result with nothing pending", '0, m_data);
            end else begin
                want = awaited_ticks.pop_front();
                if (m_data.precharge_on !== want.precharge_on
                        || m_data.main_switch_on !== want.main_switch_on
                        || m_data.seq_state !== want.seq_state
                        || m_data.fuse_trip !== want.fuse_trip
                        || m_data.overcurrent_trip !== want.overcurrent_trip
                        || m_data.precharge_fail !== want.precharge_fail
                        || m_data.filtered_current !== want.filtered_current)
                    report("result mismatch", want, m_data);
            end
        end
    end

    // Receiver: ready drops at random unless calm.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Presents one item and holds it until the block takes it. The prediction
    // is made at the accepting edge, in input order.
    task automatic send_tick(in_item_t t, bit typed, out_item_t want);
        out_item_t pred;
        s_data  <= t;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pred = step_sequencer(t);
        awaited_ticks.push_back(typed ? want : pred);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Holds the sender off until every owed result has been delivered.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_ticks.size() != 0)
            @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        @(posedge aclk);
    endtask

    initial begin
        int          hold_at;
        logic [14:0] f;
        logic [14:0] c;
        logic [15:0] mg;
        logic [15:0] to;
        logic [16:0] al;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;

        fuse_lim_q   = FUSE_LIMIT_RST;
        cur_lim_q    = CURRENT_LIMIT_RST;
        margin_q     = PRECHARGE_MARGIN_RST;
        timeout_q    = PRECHARGE_TIMEOUT_RST;
        alpha_q      = FILTER_ALPHA_RST;
        seq_q        = SEQ_CODE_OFF;
        pc_stamp_q   = '0;
        filt_acc_q   = 0;
        pc_drive_q   = 1'b0;
        main_drive_q = 1'b0;
        ms_clock     = $urandom;
        want_on      = 1'b1;
        surge_left   = 0;

        // Directed walk with the reset register values. The first three rows
        // have their results written out; the rest go through the predictor.
        drill[0]  = '{mk_tick(0, 0, 0, 0, 0, 0, 0), 1, mk_out(0, 0, SEQ_CODE_OFF)};
        drill[1]  = '{mk_tick(1, 1, 0, 0, 0, 0, 0), 1, mk_out(0, 0, SEQ_CODE_PC_START)};
        drill[2]  = '{mk_tick(100, 1, 0, 0, 0, 0, 0), 1, mk_out(1, 0, SEQ_CODE_PC)};
        // Largest battery gap, still inside the timeout.
        drill[3]  = '{mk_tick(200, 1, 16'hFFFF, 0, 0, 0, 0), 0, '0};
        // Gap just below the margin: precharge completes.
        drill[4]  = '{mk_tick(300, 1, 0, 50000, 48001, 0, 0), 0, '0};
        drill[5]  = '{mk_tick(301, 1, 0, 0, 0, 1, 100), 0, '0};
        // One step above the fuse level while on.
        drill[6]  = '{mk_tick(302, 1, 0, 0, 0, 1, 2751), 0, '0};
        drill[7]  = '{mk_tick(303, 0, 0, 0, 0, 1, -32768), 0, '0};
        drill[8]  = '{mk_tick(304, 1, 0, 0, 0, 0, 0), 0, '0};
        // Precharge starts just before the millisecond counter wraps.
        drill[9]  = '{mk_tick(32'hFFFF_FF00, 1, 0, 0, 0, 0, 0), 0, '0};
        drill[10] = '{mk_tick(32'h0000_00F0, 1, 60000, 0, 0, 0, 0), 0, '0};
        drill[11] = '{mk_tick(32'h0000_00F5, 1, 60000, 0, 0, 0, 0), 0, '0};
        drill[12] = '{mk_tick(32'h0000_00F6, 0, 0, 0, 0, 0, 0), 0, '0};
        // Sustained current at the fuse level climbs toward the filtered level but stays below it.
        for (int i = 13; i < 18; i++)
            drill[i] = '{mk_tick(32'(300 + i), 0, 0, 0, 0, 1, 2750), 0, '0};
        // Fuse trip that also lifts the filter over its level: only the instant trip reports.
        drill[18] = '{mk_tick(400, 0, 0, 0, 0, 1, 32767), 0, '0};
        drill[19] = '{mk_tick(401, 1, 0, 0, 0, 0, 0), 0, '0};
        drill[20] = '{mk_tick(10, 1, 0, 0, 0, 0, 0), 0, '0};
        drill[21] = '{mk_tick(11, 1, 40000, 40000, 40000, 0, 0), 0, '0};
        drill[22] = '{mk_tick(12, 0, 0, 0, 0, 0, 0), 0, '0};
        // Over-current while already shut down must not trip again.
        drill[23] = '{mk_tick(13, 0, 0, 0, 0, 1, 32767), 0, '0};
        drill[24] = '{mk_tick(32'hFFFF_FFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, -1), 0, '0};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        calm = 1'b0;
        foreach (drill[i]) begin
            maybe_gap();
            send_tick(drill[i].stim, drill[i].typed, drill[i].want);
        end

        for (int p = 1; p <= PHASES; p++) begin
            // Registers change only with the block idle; allow for the pass through the input
            // and result registers.
            drain();
            repeat (4) @(posedge aclk);
            case (p)
                1: begin
                    f = 15'h7FFF; c = 15'h7FFF; mg = 16'hFFFF; to = 16'd0; al = ALPHA_ONE;
                end
                2: begin
                    f = '0; c = '0; mg = '0; to = 16'hFFFF; al = '0;
                end
                3: begin
                    f = FUSE_LIMIT_RST; c = CURRENT_LIMIT_RST; mg = PRECHARGE_MARGIN_RST;
                    to = PRECHARGE_TIMEOUT_RST; al = 17'h1FFFF;
                end
                default: begin
                    f  = 15'($urandom_range(2000, 3500));
                    c  = 15'($urandom_range(1500, 3000));
                    mg = 16'($urandom_range(0, 8000));
                    to = 16'($urandom_range(0, 800));
                    al = ($urandom_range(0, 4) == 0) ? 17'($urandom)
                                                     : 17'($urandom_range(1000, 65536));
                end
            endcase
            // Bits above each register's width are junk that must be dropped.
            put_reg(CFG_FUSE_LIMIT, {2'($urandom), f});
            put_reg(CFG_CURRENT_LIMIT, {2'($urandom), c});
            put_reg(CFG_PRECHARGE_MARGIN, {1'($urandom), mg});
            put_reg(CFG_PRECHARGE_TIMEOUT, {1'($urandom), to});
            put_reg(CFG_FILTER_ALPHA, al);
            // A write to an unused index must change nothing.
            put_reg(CFG_FILTER_ALPHA + 3'($urandom_range(1, 3)), 17'($urandom));
            cfg_wr_en <= 1'b0;
            @(posedge aclk);

            hold_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The final phase runs flat out on both sides.
                if (p == PHASES)
                    calm = 1'b1;
                else if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (n == hold_at)
                    drain();
                maybe_gap();
                send_tick(random_tick(), 0, '0);
            end
        end

        s_valid <= 1'b0;
        while (awaited_ticks.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (awaited_ticks.size() != 0)
            report("result never arrived", awaited_ticks[0], '0);

        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- hv_precharge_overcurrent_sequencer_core.f -----
hw/rtl/hvps_pkg.sv
hw/rtl/hvps_filter.sv
hw/rtl/hvps_seq.sv
hw/rtl/hv_precharge_overcurrent_sequencer_core.sv
verif/tb.sv
